// ----- rtl/segment_rect_intersect_test_unit_defines.svh -----
// Assertion macros for the segment versus rectangle test unit.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef SEGMENT_RECT_INTERSECT_TEST_UNIT_DEFINES_SVH
`define SEGMENT_RECT_INTERSECT_TEST_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SRIT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRIT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRIT_ASSERT(label, prop, msg)
`define SRIT_ASSERT_RST(label, prop, msg)
`endif

`endif

// ----- rtl/srit_pkg.sv -----
// Shared constants for the segment versus rectangle test unit.
// Used by the front, queue, back and top level; depends on nothing.
package srit_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_BOTTOM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP    = 2'd3;

  localparam int CLS_W = 2;
  typedef logic [CLS_W-1:0] cls_t;
  localparam cls_t CLS_MISS  = 2'd0;
  localparam cls_t CLS_HIT   = 2'd1;
  localparam cls_t CLS_CROSS = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ----- rtl/srit_stream_if.sv -----
// Valid/ready channel interfaces for segment beats and hit beats.
// Depends on nothing.
interface srit_seg_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface srit_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// ----- rtl/srit_front.sv -----
// Front part: rectangle registers, trivial reject and inside tests, and the
// coordinate differences for the diagonal tests. Depends on srit_pkg, srit_seg_if.
module srit_front import srit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]  cfg_data,
  srit_seg_if.sink               in_seg,
  output logic                   f_valid,
  input  logic                   f_ready,
  output logic [CLS_W+7*(COORD_BITS+1)-1:0] f_data
);

  localparam int DW = COORD_BITS + 1;
  localparam int FW = CLS_W + 7 * DW;

  logic signed [COORD_BITS-1:0] rect_left_r, rect_right_r, rect_bottom_r, rect_top_r;
  logic                         f_valid_r;
  logic [FW-1:0]                f_data_r;

  logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
  logic                         reject, inside1, inside2, accept;
  cls_t                         cls;
  logic signed [DW-1:0]         ux, uy, wx, wy, ex, ey1, ey2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r   <= '0;
      rect_right_r  <= '0;
      rect_bottom_r <= '0;
      rect_top_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RECT_LEFT:   rect_left_r   <= cfg_data;
        REG_RECT_RIGHT:  rect_right_r  <= cfg_data;
        REG_RECT_BOTTOM: rect_bottom_r <= cfg_data;
        REG_RECT_TOP:    rect_top_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign x1 = in_seg.start_x;
  assign y1 = in_seg.start_y;
  assign x2 = in_seg.end_x;
  assign y2 = in_seg.end_y;

  always_comb begin
    reject = (x1 < rect_left_r && x2 < rect_left_r) ||
             (x1 > rect_right_r && x2 > rect_right_r) ||
             (y1 < rect_bottom_r && y2 < rect_bottom_r) ||
             (y1 > rect_top_r && y2 > rect_top_r);
    inside1 = x1 >= rect_left_r && x1 <= rect_right_r &&
              y1 >= rect_bottom_r && y1 <= rect_top_r;
    inside2 = x2 >= rect_left_r && x2 <= rect_right_r &&
              y2 >= rect_bottom_r && y2 <= rect_top_r;
    if (reject) begin
      cls = CLS_MISS;
    end else if (inside1 || inside2) begin
      cls = CLS_HIT;
    end else begin
      cls = CLS_CROSS;
    end
    ux  = DW'(x2) - DW'(x1);
    uy  = DW'(y2) - DW'(y1);
    wx  = DW'(rect_right_r) - DW'(rect_left_r);
    wy  = DW'(rect_top_r) - DW'(rect_bottom_r);
    ex  = DW'(x1) - DW'(rect_left_r);
    ey1 = DW'(y1) - DW'(rect_bottom_r);
    ey2 = DW'(y1) - DW'(rect_top_r);
  end

  assign in_seg.ready = !f_valid_r || f_ready;
  assign accept       = in_seg.valid && in_seg.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_seg.ready) begin
      f_valid_r <= in_seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_data_r <= {cls, ux, uy, wx, wy, ex, ey1, ey2};
    end
  end

  assign f_valid = f_valid_r;
  assign f_data  = f_data_r;

endmodule

// ----- rtl/srit_queue.sv -----
// Short queue between the front and back parts.
// Depends on srit_pkg for its depth.
module srit_queue import srit_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0]  mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push, pop;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/srit_back.sv -----
// Back part: products, cross-product sums and exact range tests against both
// diagonals, ending in the result register. Depends on srit_pkg, srit_hit_if.
module srit_back import srit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  logic [CLS_W+7*(COORD_BITS+1)-1:0] q_data,
  srit_hit_if.source             out_res
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  function automatic logic in_unit(input logic signed [SW-1:0] num,
                                   input logic signed [SW-1:0] den);
    logic res;
    if (!den[SW-1]) begin
      res = !num[SW-1] && num <= den;
    end else begin
      res = (num[SW-1] || num == '0) && num >= den;
    end
    return res;
  endfunction

  cls_t                 cls0;
  logic signed [DW-1:0] ux, uy, wx, wy, ex, ey1, ey2;
  logic                 en;

  logic                 v1_r, v2_r, out_valid_r;
  cls_t                 cls1_r, cls2_r;
  logic signed [PW-1:0] p_uxwy_r, p_uywx_r, p_e1wx_r, p_exwy_r;
  logic signed [PW-1:0] p_e1ux_r, p_exuy_r, p_e2wx_r, p_e2ux_r;
  logic signed [SW-1:0] den1_r, den2_r, n11_r, n21_r, n12_r, n22_r;
  logic                 hit_r;
  logic                 cross1, cross2, hit_nxt;

  assign {cls0, ux, uy, wx, wy, ex, ey1, ey2} = q_data;

  assign en      = !out_valid_r || out_res.ready;
  assign q_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls1_r   <= cls0;
      p_uxwy_r <= ux * wy;
      p_uywx_r <= uy * wx;
      p_e1wx_r <= ey1 * wx;
      p_exwy_r <= ex * wy;
      p_e1ux_r <= ey1 * ux;
      p_exuy_r <= ex * uy;
      p_e2wx_r <= ey2 * wx;
      p_e2ux_r <= ey2 * ux;

      cls2_r <= cls1_r;
      den1_r <= SW'(p_uxwy_r) - SW'(p_uywx_r);
      den2_r <= -SW'(p_uxwy_r) - SW'(p_uywx_r);
      n11_r  <= SW'(p_e1wx_r) - SW'(p_exwy_r);
      n21_r  <= SW'(p_e1ux_r) - SW'(p_exuy_r);
      n12_r  <= SW'(p_e2wx_r) + SW'(p_exwy_r);
      n22_r  <= SW'(p_e2ux_r) - SW'(p_exuy_r);

      hit_r <= hit_nxt;
    end
  end

  always_comb begin
    cross1 = den1_r == '0 || (in_unit(n11_r, den1_r) && in_unit(n21_r, den1_r));
    cross2 = den2_r == '0 || (in_unit(n12_r, den2_r) && in_unit(n22_r, den2_r));
    if (cls2_r == CLS_CROSS) begin
      hit_nxt = cross1 || cross2;
    end else begin
      hit_nxt = cls2_r == CLS_HIT;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.hit   = hit_r;

endmodule

// ----- rtl/segment_rect_intersect_test_unit.sv -----
// Top level of the segment versus inclusive rectangle touch test.
// Depends on srit_pkg, the channel interfaces, srit_front, srit_queue, srit_back.
//
// Write the rectangle through cfg_we/cfg_index/cfg_data while the unit is idle:
// index 0 left, 1 right, 2 bottom, 3 top, all signed. Each segment beat on in_seg
// gives exactly one hit beat on out_res, in order.
// An accepted segment beat waits in the front register, then in the queue while
// the products form, then in the product registers while the cross-product sums
// form and then in the sum registers while the range tests settle into the
// output register, where its hit beat becomes valid.
// Throughput is one beat per cycle while out_res.ready stays high, limited by the
// pipelined multipliers of the back part, which start one segment each cycle.
// Reset clears the rectangle to all zeros and empties the pipeline.
// When the receiver holds out_res.ready low, the back part holds its stages and
// the front keeps accepting until its register and the two-entry queue are full,
// after which in_seg.ready falls.
`include "segment_rect_intersect_test_unit_defines.svh"

module segment_rect_intersect_test_unit import srit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  srit_seg_if.sink              in_seg,
  srit_hit_if.source            out_res
);

  localparam int DW = COORD_BITS + 1;
  localparam int FW = CLS_W + 7 * DW;

  logic          f_valid, f_ready;
  logic [FW-1:0] f_data;
  logic          q_valid, q_ready;
  logic [FW-1:0] q_data;

  srit_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_seg    (in_seg),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_data    (f_data)
  );

  srit_queue #(.WIDTH(FW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  srit_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .out_res (out_res)
  );

  `SRIT_ASSERT_RST(a_reset_empty, !rst_n |=> !out_res.valid, "result valid after reset")
  `SRIT_ASSERT(a_front_loaded, in_seg.valid && in_seg.ready |=> f_valid, "beat lost in front")
  `SRIT_ASSERT(a_back_holds, out_res.valid && !out_res.ready |-> !q_ready, "back moved while stalled")

endmodule

// ----- bench/segment_rect_intersect_test_unit_tb.sv -----
// Testbench for segment_rect_intersect_test_unit: directed and random segment beats
// against several rectangles, each hit beat compared with a typed expectation or a built-in predictor.
// Depends on srit_pkg, the channel interfaces in srit_stream_if.sv and the unit itself.
module segment_rect_intersect_test_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srit_pkg::*;

  localparam int COORD_BITS     = 16;
  localparam longint COORD_MIN  = -32768;
  localparam longint COORD_MAX  = 32767;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_ITEMS    = 200;
  localparam int SQUEEZE_AT     = 300;
  localparam int SQUEEZE_CYCLES = 150;
  localparam int MAX_REPORTS    = 10;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } segment_t;

  typedef struct {
    segment_t seg;
    bit       hit;
  } pending_hit_t;

  typedef enum bit {ROW_RECT, ROW_SEG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        v[4];
    bit        typed;
    bit        hit;
  } directed_row_t;

  // Rectangle rows hold left, right, bottom, top; segment rows hold the two endpoints.
  directed_row_t directed [27] = '{
    '{ROW_SEG,  '{0, 0, 0, 0},                          1'b1, 1'b1},
    '{ROW_SEG,  '{-32768, -32768, -1, -1},              1'b1, 1'b0},
    '{ROW_SEG,  '{1, 1, 32767, 32767},                  1'b1, 1'b0},
    '{ROW_SEG,  '{-32768, 5, 32767, 5},                 1'b1, 1'b0},
    '{ROW_SEG,  '{-32768, -32768, 32767, 32767},        1'b1, 1'b1},
    '{ROW_RECT, '{-100, 100, -50, 50},                  1'b0, 1'b0},
    '{ROW_SEG,  '{-200, 0, 200, 0},                     1'b0, 1'b0},
    '{ROW_SEG,  '{-100, -50, -100, -50},                1'b0, 1'b0},
    '{ROW_SEG,  '{-120, -200, 280, 0},                  1'b0, 1'b0},
    '{ROW_SEG,  '{-110, -40, -90, -60},                 1'b0, 1'b0},
    '{ROW_SEG,  '{-200, 40, -90, 60},                   1'b0, 1'b0},
    '{ROW_SEG,  '{101, -60, 101, 60},                   1'b1, 1'b0},
    '{ROW_SEG,  '{-150, -49, -99, -200},                1'b0, 1'b0},
    '{ROW_SEG,  '{32767, 32767, -32768, -32768},        1'b0, 1'b0},
    '{ROW_RECT, '{-32768, 32767, -32768, 32767},        1'b0, 1'b0},
    '{ROW_SEG,  '{-32768, -32768, -32768, -32768},      1'b1, 1'b1},
    '{ROW_SEG,  '{32767, -32768, -32768, 32767},        1'b1, 1'b1},
    '{ROW_SEG,  '{32767, 32767, 32767, 32767},          1'b1, 1'b1},
    '{ROW_RECT, '{32767, -32768, 32767, -32768},        1'b0, 1'b0},
    '{ROW_SEG,  '{0, 0, 0, 0},                          1'b1, 1'b0},
    '{ROW_SEG,  '{32767, 32767, -32768, -32768},        1'b0, 1'b0},
    '{ROW_SEG,  '{32767, -32768, -32768, 32767},        1'b0, 1'b0},
    '{ROW_RECT, '{5, 5, -1000, 1000},                   1'b0, 1'b0},
    '{ROW_SEG,  '{0, 0, 10, 0},                         1'b0, 1'b0},
    '{ROW_SEG,  '{5, 2000, 5, -2000},                   1'b0, 1'b0},
    '{ROW_SEG,  '{4, -1000, 6, 1000},                   1'b0, 1'b0},
    '{ROW_SEG,  '{6, 1001, 4, -1001},                   1'b0, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [COORD_BITS-1:0] cfg_data;

  srit_seg_if #(.COORD_BITS(COORD_BITS)) seg_bus ();
  srit_hit_if hit_bus ();

  segment_rect_intersect_test_unit #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_seg    (seg_bus),
    .out_res   (hit_bus)
  );

  coord_t rect_left   = '0;
  coord_t rect_right  = '0;
  coord_t rect_bottom = '0;
  coord_t rect_top    = '0;

  pending_hit_t pending_hits [$];
  int fail_count    = 0;
  int results_seen  = 0;
  int hits_seen     = 0;
  int rect_settings = 1;
  int quiet_cycles  = 0;
  bit feed_burst    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic coord_t clamp_coord(longint v);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic longint rand_span(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit within_unit(longint num, longint den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  // A zero denominator means the segment runs parallel to the diagonal, counted as a hit.
  function automatic bit crosses_diagonal(input longint ax, ay, bx, by, cx, cy, dx, dy);
    longint ux, uy, wx, wy, ex, ey, den;
    ux  = bx - ax;
    uy  = by - ay;
    wx  = dx - cx;
    wy  = dy - cy;
    ex  = ax - cx;
    ey  = ay - cy;
    den = ux * wy - uy * wx;
    if (den == 0) return 1'b1;
    return within_unit(ey * wx - ex * wy, den) && within_unit(ey * ux - ex * uy, den);
  endfunction

  function automatic bit predict_touch(segment_t s);
    longint x1, y1, x2, y2, l, r, b, t;
    x1 = $signed(s.start_x);
    y1 = $signed(s.start_y);
    x2 = $signed(s.end_x);
    y2 = $signed(s.end_y);
    l  = rect_left;
    r  = rect_right;
    b  = rect_bottom;
    t  = rect_top;
    if ((x1 < l && x2 < l) || (x1 > r && x2 > r) || (y1 < b && y2 < b) || (y1 > t && y2 > t))
      return 1'b0;
    if ((x1 >= l && x1 <= r && y1 >= b && y1 <= t) || (x2 >= l && x2 <= r && y2 >= b && y2 <= t))
      return 1'b1;
    return crosses_diagonal(x1, y1, x2, y2, l, b, r, t) ||
           crosses_diagonal(x1, y1, x2, y2, l, t, r, b);
  endfunction

  // Most segments are placed around the current rectangle so that they reach the
  // diagonal tests; a share are fully random words.
  function automatic segment_t make_segment();
    segment_t s;
    longint lo_x, hi_x, lo_y, hi_y, mx, my, px, py, qx, qy, dx, dy, k;
    int shape;
    lo_x  = (rect_left < rect_right) ? rect_left : rect_right;
    hi_x  = (rect_left < rect_right) ? rect_right : rect_left;
    lo_y  = (rect_bottom < rect_top) ? rect_bottom : rect_top;
    hi_y  = (rect_bottom < rect_top) ? rect_top : rect_bottom;
    mx    = (hi_x - lo_x) / 2 + 4;
    my    = (hi_y - lo_y) / 2 + 4;
    shape = $urandom_range(0, 99);
    if (shape < 15) begin
      s = segment_t'({$urandom(), $urandom()});
      return s;
    end
    px = rand_span(lo_x - mx, hi_x + mx);
    py = rand_span(lo_y - my, hi_y + my);
    qx = rand_span(lo_x - mx, hi_x + mx);
    qy = rand_span(lo_y - my, hi_y + my);
    k  = $urandom_range(1, 3);
    if (shape >= 45 && shape < 60) begin
      px = rand_span(lo_x, hi_x);
      py = rand_span(lo_y, hi_y);
    end else if (shape >= 60 && shape < 75) begin
      dx = longint'(rect_right) - rect_left;
      dy = $urandom_range(0, 1) ? longint'(rect_top) - rect_bottom
                                : longint'(rect_bottom) - rect_top;
      if ($urandom_range(0, 1)) k = -k;
      qx = px + k * dx;
      qy = py + k * dy;
    end else if (shape >= 75 && shape < 90) begin
      dx = rand_span(-mx, mx);
      dy = rand_span(-my, my);
      qx = $urandom_range(0, 1) ? rect_left : rect_right;
      qy = $urandom_range(0, 1) ? rect_bottom : rect_top;
      px = qx - k * dx;
      py = qy - k * dy;
      qx = qx + dx;
      qy = qy + dy;
    end else if (shape >= 90) begin
      if ($urandom_range(0, 1)) begin
        py = rand_span(lo_y - 2, hi_y + 2);
        qy = py;
        px = lo_x - rand_span(1, mx);
        qx = hi_x + rand_span(0, mx);
      end else begin
        px = rand_span(lo_x - 2, hi_x + 2);
        qx = px;
        py = lo_y - rand_span(1, my);
        qy = hi_y + rand_span(0, my);
      end
    end
    if ($urandom_range(0, 1)) begin
      s.start_x = clamp_coord(px);
      s.start_y = clamp_coord(py);
      s.end_x   = clamp_coord(qx);
      s.end_y   = clamp_coord(qy);
    end else begin
      s.start_x = clamp_coord(qx);
      s.start_y = clamp_coord(qy);
      s.end_x   = clamp_coord(px);
      s.end_y   = clamp_coord(py);
    end
    return s;
  endfunction

  task automatic note_failure(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", what);
  endtask

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic offer_segment(segment_t s, bit typed, bit typed_hit);
    int gap;
    pending_hit_t entry;
    gap = pick_gap(feed_burst);
    if (gap > 0) begin
      seg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_bus.valid   <= 1'b1;
    seg_bus.start_x <= s.start_x;
    seg_bus.start_y <= s.start_y;
    seg_bus.end_x   <= s.end_x;
    seg_bus.end_y   <= s.end_y;
    @(posedge clk);
    while (!seg_bus.ready) @(posedge clk);
    entry.seg = s;
    entry.hit = typed ? typed_hit : predict_touch(s);
    pending_hits.push_back(entry);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= clamp_coord(v);
    case (idx)
      REG_RECT_LEFT:   rect_left   = clamp_coord(v);
      REG_RECT_RIGHT:  rect_right  = clamp_coord(v);
      REG_RECT_BOTTOM: rect_bottom = clamp_coord(v);
      REG_RECT_TOP:    rect_top    = clamp_coord(v);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // The rectangle is only changed once every pending hit beat has come back.
  task automatic load_rectangle(longint l, longint r, longint b, longint t);
    seg_bus.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_RECT_LEFT, l);
    write_reg(REG_RECT_RIGHT, r);
    write_reg(REG_RECT_BOTTOM, b);
    write_reg(REG_RECT_TOP, t);
    cfg_we <= 1'b0;
    rect_settings++;
  endtask

  initial begin : segment_feed
    segment_t s;
    longint cx, cy, hw, hh, l, r, b, t, swap;
    int fed;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_RECT_LEFT;
    cfg_data        <= '0;
    seg_bus.valid   <= 1'b0;
    seg_bus.start_x <= '0;
    seg_bus.start_y <= '0;
    seg_bus.end_x   <= '0;
    seg_bus.end_y   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_RECT) begin
        load_rectangle(directed[i].v[0], directed[i].v[1], directed[i].v[2], directed[i].v[3]);
      end else begin
        s.start_x = coord_t'(directed[i].v[0]);
        s.start_y = coord_t'(directed[i].v[1]);
        s.end_x   = coord_t'(directed[i].v[2]);
        s.end_y   = coord_t'(directed[i].v[3]);
        offer_segment(s, directed[i].typed, directed[i].hit);
      end
    end

    fed = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      cx = rand_span(COORD_MIN, COORD_MAX);
      cy = rand_span(COORD_MIN, COORD_MAX);
      hw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, 300);
      hh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, 300);
      l  = cx - hw;
      r  = cx + hw;
      b  = cy - hh;
      t  = cy + hh;
      if (phase == 3) begin
        l = COORD_MIN;
        r = COORD_MAX;
        b = COORD_MIN;
        t = COORD_MAX;
      end
      if (phase >= 5) begin
        swap = l;
        l    = r;
        r    = swap;
      end
      if (phase == 5) begin
        swap = b;
        b    = t;
        t    = swap;
      end
      load_rectangle(l, r, b, t);
      repeat (PHASE_ITEMS) begin
        if (fed % 64 == 0) feed_burst = ($urandom_range(0, 3) == 0);
        offer_segment(make_segment(), 1'b0, 1'b0);
        fed++;
      end
    end
    seg_bus.valid <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_hits.size() != 0)
      note_failure($sformatf("%0d hit beats never arrived", pending_hits.size()));
    $display("Checked %0d hit beats (%0d hits) over %0d rectangle settings,",
             results_seen, hits_seen, rect_settings);
    $display("including inverted, degenerate and full-range rectangles; %0d mismatches.",
             fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : hit_sink
    pending_hit_t want;
    int hold_left;
    bit burst;
    hold_left = 0;
    burst     = 1'b0;
    hit_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && hit_bus.valid && hit_bus.ready) begin
        if (pending_hits.size() == 0) begin
          note_failure($sformatf("hit beat %b arrived with nothing pending", hit_bus.hit));
        end else begin
          want = pending_hits.pop_front();
          if (hit_bus.hit !== want.hit)
            note_failure($sformatf("segment (%0d,%0d)-(%0d,%0d): expected hit %0b, got %b",
                                   want.seg.start_x, want.seg.start_y, want.seg.end_x,
                                   want.seg.end_y, want.hit, hit_bus.hit));
        end
        results_seen++;
        if (hit_bus.hit === 1'b1) hits_seen++;
        if (results_seen % 64 == 0) burst = ($urandom_range(0, 3) == 0);
        // One long hold-off lets the pipeline fill and push back on the sender.
        hold_left = (results_seen == SQUEEZE_AT) ? SQUEEZE_CYCLES : pick_gap(burst);
      end
      if (hold_left > 0) begin
        hit_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        hit_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((seg_bus.valid && seg_bus.ready) || (hit_bus.valid && hit_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out after %0d cycles without a beat", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/srit_pkg.sv
rtl/srit_stream_if.sv
rtl/srit_front.sv
rtl/srit_queue.sv
rtl/srit_back.sv
rtl/segment_rect_intersect_test_unit.sv
bench/segment_rect_intersect_test_unit_tb.sv
